// ===== design/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types and constants for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wbps_pkg;

  // Sizes
  localparam int MAX_PATTERN   = 16;  // depth of the byte window
  localparam int OFFSET_BITS   = 32;  // width of the byte count and match offset
  localparam int ADDR_BITS     = 48;
  localparam int REG_BYTES     = 16;  // pattern bytes held in registers
  localparam int LEN_BITS      = 5;
  localparam int WIN_IDX_BITS  = $clog2(MAX_PATTERN);
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 64;

  // Register indices
  localparam logic [CFG_IDX_BITS-1:0] REG_REGION_BASE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WILDCARD_MASK  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_REQUIRE_UNIQUE = 3'd5;

  // Status codes
  localparam logic [1:0] STATUS_FOUND     = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_AMBIGUOUS = 2'd2;
  localparam logic [1:0] STATUS_INVALID   = 2'd3;

  // Input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [ADDR_BITS-1:0] match_address;
    logic [1:0]           scan_status;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [ADDR_BITS-1:0]     region_base;
    logic [CFG_DATA_BITS-1:0] pattern_bytes_low;
    logic [CFG_DATA_BITS-1:0] pattern_bytes_high;
    logic [REG_BYTES-1:0]     wildcard_mask;
    logic [LEN_BITS-1:0]      pattern_length;
    logic                     require_unique;
  } cfg_t;

  // Window compare outcome for one byte step
  typedef struct packed {
    logic hit;        // window ending at this byte matches the pattern
    logic pat_valid;  // pattern is usable at all
  } match_t;

endpackage

// ===== design/wbps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wbps_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wbps_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output wbps_pkg::cfg_t                      cfg_o
);

  wbps_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // Register decode; unknown indices are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        wbps_pkg::REG_REGION_BASE:
          cfg_d.region_base = cfg_data_i[wbps_pkg::ADDR_BITS-1:0];
        wbps_pkg::REG_PATTERN_LOW:    cfg_d.pattern_bytes_low  = cfg_data_i;
        wbps_pkg::REG_PATTERN_HIGH:   cfg_d.pattern_bytes_high = cfg_data_i;
        wbps_pkg::REG_WILDCARD_MASK:
          cfg_d.wildcard_mask = cfg_data_i[wbps_pkg::REG_BYTES-1:0];
        wbps_pkg::REG_PATTERN_LENGTH:
          cfg_d.pattern_length = cfg_data_i[wbps_pkg::LEN_BITS-1:0];
        wbps_pkg::REG_REQUIRE_UNIQUE: cfg_d.require_unique = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // All zero at reset except require_unique
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= wbps_pkg::cfg_t'{require_unique: 1'b1, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/wbps_window_match.sv =====
// ----------------------------------------------------------------------------
// wbps_window_match
// Sliding byte window and the parallel wildcard compare against the pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_window_match (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,   // item processed this cycle
  input  wbps_pkg::in_item_t    item_i,
  input  wbps_pkg::cfg_t        cfg_i,
  output wbps_pkg::match_t      match_o
);

  localparam int MP = wbps_pkg::MAX_PATTERN;
  localparam int RB = wbps_pkg::REG_BYTES;
  localparam int LB = wbps_pkg::LEN_BITS;

  logic [MP-1:0][7:0]                     window_q, window_d;
  logic [MP-1:0][7:0]                     win_new;
  logic [RB-1:0][7:0]                     pat;
  logic [RB-1:0]                          in_use;
  logic [RB-1:0]                          cmp_ok;
  logic [RB-1:0][wbps_pkg::WIN_IDX_BITS-1:0] win_idx;
  logic [LB-1:0]                          len;

  assign len = cfg_i.pattern_length;
  assign pat = {cfg_i.pattern_bytes_high, cfg_i.pattern_bytes_low};

  // Window after this byte: entry k holds the byte taken k steps ago
  always_comb begin
    win_new[0] = item_i.data_byte;
    for (int k = 1; k < MP; k++) begin
      win_new[k] = window_q[k-1];
    end
  end

  // Pattern byte i lines up with window entry len-1-i
  for (genvar i = 0; i < RB; i++) begin : g_cmp
    logic [LB-1:0] idx_full;
    assign idx_full   = len - LB'(i) - LB'(1);
    assign win_idx[i] = idx_full[wbps_pkg::WIN_IDX_BITS-1:0];
    assign in_use[i]  = LB'(i) < len;
    assign cmp_ok[i]  = !in_use[i] || cfg_i.wildcard_mask[i] ||
                        (win_new[win_idx[i]] == pat[i]);
  end

  assign match_o.hit       = &cmp_ok;
  assign match_o.pat_valid = (len != '0) &&
                             (32'(len) <= 32'(RB)) && (32'(len) <= 32'(MP)) &&
                             (|(in_use & ~cfg_i.wildcard_mask));

  // Shift on every item; clear after the last byte of a region
  always_comb begin
    window_d = window_q;
    if (step_i) begin
      window_d = item_i.last_byte ? '0 : win_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else begin
      window_q <= window_d;
    end
  end

endmodule

// ===== design/wbps_tally.sv =====
// ----------------------------------------------------------------------------
// wbps_tally
// Byte count, match tally and first match offset; forms the region result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_tally (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic                  last_i,
  input  wbps_pkg::match_t      match_i,
  input  wbps_pkg::cfg_t        cfg_i,
  output wbps_pkg::out_item_t   result_o
);

  localparam int OB = wbps_pkg::OFFSET_BITS;

  logic [OB-1:0] seen_q, seen_d, seen_inc;
  logic [OB-1:0] first_q, first_d;
  logic [1:0]    tally_q, tally_d;
  logic          not_sat;
  logic          count;

  // Next scan state for this byte
  always_comb begin
    not_sat  = seen_q != '1;
    seen_inc = seen_q + OB'(1);
    count    = not_sat && match_i.pat_valid && match_i.hit &&
               (seen_inc >= OB'(cfg_i.pattern_length));
    seen_d   = not_sat ? seen_inc : seen_q;
    first_d  = (count && tally_q == 2'd0) ?
               (seen_inc - OB'(cfg_i.pattern_length)) : first_q;
    tally_d  = (count && tally_q != 2'd2) ? tally_q + 2'd1 : tally_q;
  end

  // Region result, meaningful on the last byte
  always_comb begin
    result_o.match_address = '0;
    if (!match_i.pat_valid) begin
      result_o.scan_status = wbps_pkg::STATUS_INVALID;
    end else if (tally_d == 2'd0) begin
      result_o.scan_status = wbps_pkg::STATUS_NOT_FOUND;
    end else if (cfg_i.require_unique && tally_d == 2'd2) begin
      result_o.scan_status = wbps_pkg::STATUS_AMBIGUOUS;
    end else begin
      result_o.scan_status   = wbps_pkg::STATUS_FOUND;
      result_o.match_address = cfg_i.region_base + wbps_pkg::ADDR_BITS'(first_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      first_q <= '0;
      tally_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        seen_q  <= '0;
        first_q <= '0;
        tally_q <= '0;
      end else begin
        seen_q  <= seen_d;
        first_q <= first_d;
        tally_q <= tally_d;
      end
    end
  end

endmodule

// ===== design/wildcard_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams region bytes through a 16-byte window, matches a wildcard pattern
// and gives one status/address item per region on its last byte.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o  in_item_i (data_byte, last_byte)
// out      out        out_valid_o/out_ready_i out_item_o (match_address, status)
//
// One byte per cycle sustained: input register, window compare and tally
// update, then the result register. The result register loads when the last
// byte advances out of the input register, so the result is valid in the
// cycle after that advance. Reset clears the window, the counters, the valid
// flags and the config registers (require_unique to 1). A stalled result only
// holds up the pipeline when another last byte reaches the compare stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wbps_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [wbps_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wbps_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wbps_pkg::out_item_t                 out_item_o
);

  wbps_pkg::cfg_t      cfg;
  wbps_pkg::match_t    match;
  wbps_pkg::in_item_t  in_item_q;
  wbps_pkg::out_item_t out_item_q, result;
  logic                in_vld_q, out_vld_q;
  logic                out_free, advance;

  wbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline flow: non-last items always move, last ones need the result slot
  assign out_free   = !out_vld_q || out_ready_i;
  assign advance    = in_vld_q && (!in_item_q.last_byte || out_free);
  assign in_ready_o = !in_vld_q || advance;

  wbps_window_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .match_o (match)
  );

  wbps_tally u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .last_i   (in_item_q.last_byte),
    .match_i  (match),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_item_q.last_byte) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_item_q.last_byte) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

endmodule
